@@ rtl/mtlp_pkg.sv @@
// Shared types, character codes and helpers of the memory trace line parser.
package mtlp_pkg;

	localparam int unsigned ADDR_W = 64;

	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_OPCODE = 2'd1,
		ST_NO_SPACE   = 2'd2,
		ST_BAD_TERM   = 2'd3
	} status_t;

	typedef struct packed {
		logic                operation;
		logic [ADDR_W-1:0]   address;
		status_t             status;
	} mtlp_rec_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] nibble;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.is_hex = 1'b1;
		h.nibble = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.nibble = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.nibble = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.nibble = 4'(c - 8'h37);
		end else begin
			h.is_hex = 1'b0;
		end
		return h;
	endfunction

endpackage

@@ rtl/mtlp_if.sv @@
// Valid/ready channel interfaces for trace bytes and parsed records.
interface mtlp_byte_if;
	import mtlp_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface mtlp_rec_if;
	import mtlp_pkg::*;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [ADDR_W-1:0] address;
	logic [1:0]        status;
	modport source(output valid, operation, address, status, input ready);
	modport sink(input valid, operation, address, status, output ready);
endinterface

@@ rtl/memory_trace_line_parser_unit.sv @@
// Top level of the memory trace line parser: input stage, parser core, output register.
//
// trace_in carries one text byte per word (data_byte, with last_byte marking the
// end of the stream); record_out carries one parsed record per word (operation,
// address, status). Records are "LD " or "ST ", an optional two-byte prefix ending
// in x or X, then hex digits, closed by newline, carriage return or the last byte.
// An accepted byte is held in the input stage register, stepped through the parser
// core, and its record, if any, is captured in the output register.
// Throughput: one byte per cycle while record_out does not stall.
// A byte may produce no record; at most one record per byte.
// After an error record the block drops bytes up to and including the last byte.
// When record_out stalls, the output register holds its word and the input stage
// keeps one byte; trace_in.ready falls only when both are full.
// Reset (arst_n low) clears the parser state and the valid flags of the input stage
// and the output register; the first byte after reset opens a new record.
module memory_trace_line_parser_unit import mtlp_pkg::*; #(
	parameter int unsigned ADDR_BITS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	mtlp_byte_if.sink    trace_in,
	mtlp_rec_if.source   record_out
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       out_valid_q;
	mtlp_rec_t  out_rec_q;
	logic       advance, step, res_valid;
	mtlp_rec_t  rec;

	assign advance        = !out_valid_q || record_out.ready;
	assign step           = valid_s1 && advance;
	assign trace_in.ready = !valid_s1 || advance;

	mtlp_core #(.ADDR_BITS(ADDR_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res_valid (res_valid),
		.rec       (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (trace_in.ready) begin
				valid_s1 <= trace_in.valid;
			end
			if (advance) begin
				out_valid_q <= step && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (trace_in.valid && trace_in.ready) begin
			data_s1 <= trace_in.data_byte;
			last_s1 <= trace_in.last_byte;
		end
		if (step && res_valid) begin
			out_rec_q <= rec;
		end
	end

	assign record_out.valid     = out_valid_q;
	assign record_out.operation = out_rec_q.operation;
	assign record_out.address   = out_rec_q.address;
	assign record_out.status    = out_rec_q.status;

endmodule

@@ rtl/mtlp_core.sv @@
// Record parsing state machine: consumes one byte per step, yields at most one record.
module mtlp_core import mtlp_pkg::*; #(
	parameter int unsigned ADDR_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       res_valid,
	output mtlp_rec_t  rec
);

	typedef enum logic [2:0] {
		P_OP0, P_OP1, P_SPACE, P_FIRST, P_HELD, P_HEX
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [7:0]           opf_q, opf_d;
	logic [7:0]           held_q, held_d;
	logic [ADDR_BITS-1:0] acc_q, acc_d;
	logic                 halted_q, halted_d;

	hex_t                 c_hex, held_hex;
	logic [ADDR_BITS-1:0] acc_base, acc_next;
	logic                 op_kind, opcode_ok, is_eol, held_eol;

	assign c_hex     = hex_decode(data_byte);
	assign held_hex  = hex_decode(held_q);
	assign op_kind   = (opf_q == CH_S);
	assign opcode_ok = (opf_q == CH_L && held_q == CH_D) || (opf_q == CH_S && held_q == CH_T);
	assign is_eol    = (data_byte == CH_LF) || (data_byte == CH_CR);
	assign held_eol  = (held_q == CH_LF) || (held_q == CH_CR);
	assign acc_base  = (phase_q == P_HELD) ? ADDR_BITS'(held_hex.nibble) : acc_q;
	assign acc_next  = {acc_base[ADDR_BITS-5:0], c_hex.nibble};

	always_comb begin
		phase_d       = phase_q;
		opf_d         = opf_q;
		held_d        = held_q;
		acc_d         = acc_q;
		halted_d      = halted_q;
		res_valid     = 1'b0;
		rec.operation = 1'b0;
		rec.address   = '0;
		rec.status    = ST_OK;
		if (halted_q) begin
			if (last_byte) begin
				halted_d = 1'b0;
			end
		end else begin
			unique case (phase_q)
				P_OP0: begin
					opf_d   = data_byte;
					phase_d = P_OP1;
				end
				P_OP1: begin
					held_d  = data_byte;
					phase_d = P_SPACE;
				end
				P_SPACE: begin
					if (!last_byte) begin
						if (!opcode_ok) begin
							res_valid  = 1'b1;
							rec.status = ST_BAD_OPCODE;
							halted_d   = 1'b1;
						end else if (data_byte != CH_SPACE) begin
							res_valid     = 1'b1;
							rec.operation = op_kind;
							rec.status    = ST_NO_SPACE;
							halted_d      = 1'b1;
						end else begin
							acc_d   = '0;
							phase_d = P_FIRST;
						end
					end
				end
				P_FIRST: begin
					if (last_byte) begin
						res_valid     = 1'b1;
						rec.operation = op_kind;
						rec.address   = c_hex.is_hex ? ADDR_W'(c_hex.nibble) : '0;
					end else begin
						held_d  = data_byte;
						phase_d = P_HELD;
					end
				end
				P_HELD, P_HEX: begin
					if (phase_q == P_HELD && (data_byte == CH_LX || data_byte == CH_UX)) begin
						acc_d   = '0;
						phase_d = P_HEX;
						if (last_byte) begin
							res_valid     = 1'b1;
							rec.operation = op_kind;
						end
					end else if (phase_q == P_HELD && !held_hex.is_hex) begin
						res_valid     = 1'b1;
						rec.operation = op_kind;
						if (held_q == CH_LF || held_q == CH_CR) begin
							opf_d   = data_byte;
							phase_d = P_OP1;
						end else begin
							rec.status = ST_BAD_TERM;
							halted_d   = 1'b1;
						end
					end else if (c_hex.is_hex) begin
						acc_d   = acc_next;
						phase_d = P_HEX;
						if (last_byte) begin
							res_valid     = 1'b1;
							rec.operation = op_kind;
							rec.address   = ADDR_W'(acc_next);
						end
					end else begin
						res_valid     = 1'b1;
						rec.operation = op_kind;
						if (is_eol || last_byte) begin
							rec.address = ADDR_W'(acc_base);
						end else begin
							rec.status = ST_BAD_TERM;
							halted_d   = 1'b1;
						end
					end
				end
				default: ;
			endcase
			if (res_valid && !(phase_q == P_HELD && !held_hex.is_hex && held_eol)) begin
				phase_d = P_OP0;
				opf_d   = '0;
				held_d  = '0;
				acc_d   = '0;
			end
			if (last_byte) begin
				phase_d  = P_OP0;
				opf_d    = '0;
				held_d   = '0;
				acc_d    = '0;
				halted_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= P_OP0;
			opf_q    <= '0;
			held_q   <= '0;
			acc_q    <= '0;
			halted_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			opf_q    <= opf_d;
			held_q   <= (res_valid && phase_q == P_HELD && !held_hex.is_hex && held_eol)
			            ? '0 : held_d;
			acc_q    <= acc_d;
			halted_q <= halted_d;
		end
	end

endmodule
